// ===== hw/rtl/tlvd_pkg.sv =====
`default_nettype none

package tlvd_pkg;

    // Byte classification codes
    typedef enum logic [2:0] {
        KIND_REQ_TYPE = 3'd0,
        KIND_PKT_LEN  = 3'd1,
        KIND_TLV_TYPE = 3'd2,
        KIND_TLV_LEN  = 3'd3,
        KIND_VALUE    = 3'd4,
        KIND_IGNORED  = 3'd5
    } kind_t;

    // Error codes
    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_ZERO_TLV    = 3'd1,
        ERR_OVERRUN     = 3'd2,
        ERR_ZERO_PKT    = 3'd3,
        ERR_TOO_MANY    = 3'd4
    } err_t;

    // Saturation point of the reported TLV index
    localparam logic [7:0] TLV_NUM_SAT = 8'd15;

    // One classified byte
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  byte_out;
        logic [3:0]  tlv_number;
        logic [7:0]  value_pos;
        logic        tlv_last;
        logic        packet_last;
        err_t        error;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tlv_packet_deframer.sv =====
// Each accepted byte's result is registered in the result register, or in the skid register while the output stalls.
// Throughput: one byte per cycle while in_stall is low; the parse state is updated by one level of counter logic.
// A two-entry output stage (result register plus skid register) lets input take one more byte
// while the output side stalls; in_stall is the skid register's valid bit.
// Reset (rst_n low, asynchronous) returns the parser to idle and empties the output stage.
`default_nettype none

module tlv_packet_deframer #(
    parameter int MAX_TLVS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            byte_in,
    input  wire logic                  start_req,
    // output channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output tlvd_pkg::kind_t            kind,
    output logic [7:0]                 byte_out,
    output logic [3:0]                 tlv_number,
    output logic [7:0]                 value_pos,
    output logic                       tlv_last,
    output logic                       packet_last,
    output tlvd_pkg::err_t             error
);
    import tlvd_pkg::*;

    localparam int CW = $clog2(MAX_TLVS + 1);
    localparam logic [CW-1:0] TLV_LIMIT = CW'(MAX_TLVS);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEN,
        PH_TTYPE,
        PH_TLEN,
        PH_VALUE
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [7:0]      packet_left_reg, packet_left_next;
    logic [7:0]      value_left_reg, value_left_next;
    logic [CW-1:0]   tlv_count_reg, tlv_count_next;
    logic [7:0]      value_index_reg, value_index_next;

    result_t         main_reg, main_next;
    logic            main_valid_reg, main_valid_next;
    result_t         skid_reg, skid_next;
    logic            skid_valid_reg, skid_valid_next;

    result_t         res;
    logic            in_acc;
    logic            out_acc;
    logic [7:0]      tlv_wide;
    logic [3:0]      tlv_num_sat;
    logic [7:0]      pkt_dec;
    logic [7:0]      val_dec;

    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = main_valid_reg && !out_stall;
    assign in_stall = skid_valid_reg;

    // Saturated TLV index and shared decrements
    assign tlv_wide    = 8'(tlv_count_reg);
    assign tlv_num_sat = (tlv_wide > TLV_NUM_SAT) ? TLV_NUM_SAT[3:0] : tlv_wide[3:0];
    assign pkt_dec     = packet_left_reg - 8'd1;
    assign val_dec     = value_left_reg - 8'd1;

    // Byte classification and parse state update
    always_comb
    begin
        phase_next       = phase_reg;
        packet_left_next = packet_left_reg;
        value_left_next  = value_left_reg;
        tlv_count_next   = tlv_count_reg;
        value_index_next = value_index_reg;

        res             = '0;
        res.kind        = KIND_IGNORED;
        res.byte_out    = byte_in;
        res.error       = ERR_NONE;

        if (start_req)
        begin
            res.kind         = KIND_REQ_TYPE;
            phase_next       = PH_LEN;
            packet_left_next = '0;
            value_left_next  = '0;
            tlv_count_next   = '0;
            value_index_next = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_LEN:
                begin
                    res.kind         = KIND_PKT_LEN;
                    packet_left_next = byte_in;
                    if (byte_in == 8'd0)
                    begin
                        res.error       = ERR_ZERO_PKT;
                        res.packet_last = 1'b1;
                        phase_next      = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_TTYPE;
                    end
                end
                PH_TTYPE:
                begin
                    res.kind       = KIND_TLV_TYPE;
                    res.tlv_number = tlv_num_sat;
                    if (tlv_count_reg >= TLV_LIMIT)
                    begin
                        res.error       = ERR_TOO_MANY;
                        res.packet_last = 1'b1;
                        phase_next      = PH_IDLE;
                    end
                    else
                    begin
                        packet_left_next = pkt_dec;
                        if (pkt_dec == 8'd0)
                        begin
                            res.error       = ERR_OVERRUN;
                            res.packet_last = 1'b1;
                            phase_next      = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_TLEN;
                        end
                    end
                end
                PH_TLEN:
                begin
                    res.kind         = KIND_TLV_LEN;
                    res.tlv_number   = tlv_num_sat;
                    packet_left_next = pkt_dec;
                    if (byte_in == 8'd0)
                    begin
                        res.error       = ERR_ZERO_TLV;
                        res.packet_last = 1'b1;
                        phase_next      = PH_IDLE;
                    end
                    else if (byte_in > pkt_dec)
                    begin
                        res.error       = ERR_OVERRUN;
                        res.packet_last = 1'b1;
                        phase_next      = PH_IDLE;
                    end
                    else
                    begin
                        value_left_next  = byte_in;
                        value_index_next = '0;
                        phase_next       = PH_VALUE;
                    end
                end
                PH_VALUE:
                begin
                    res.kind         = KIND_VALUE;
                    res.tlv_number   = tlv_num_sat;
                    res.value_pos    = value_index_reg;
                    packet_left_next = pkt_dec;
                    value_left_next  = val_dec;
                    if (val_dec == 8'd0)
                    begin
                        res.tlv_last     = 1'b1;
                        tlv_count_next   = tlv_count_reg + CW'(1);
                        value_index_next = '0;
                        if (pkt_dec == 8'd0)
                        begin
                            res.packet_last = 1'b1;
                            phase_next      = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_TTYPE;
                        end
                    end
                    else
                    begin
                        value_index_next = value_index_reg + 8'd1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Output stage: result register with one skid entry
    always_comb
    begin
        main_next       = main_reg;
        main_valid_next = main_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (out_acc || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = res;
                main_valid_next = in_acc;
            end
        end
        else if (in_acc)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    // State and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            packet_left_reg <= '0;
            value_left_reg  <= '0;
            tlv_count_reg   <= '0;
            value_index_reg <= '0;
            main_reg        <= '0;
            main_valid_reg  <= 1'b0;
            skid_reg        <= '0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                phase_reg       <= phase_next;
                packet_left_reg <= packet_left_next;
                value_left_reg  <= value_left_next;
                tlv_count_reg   <= tlv_count_next;
                value_index_reg <= value_index_next;
            end
            main_reg       <= main_next;
            main_valid_reg <= main_valid_next;
            skid_reg       <= skid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    assign out_valid   = main_valid_reg;
    assign kind        = main_reg.kind;
    assign byte_out    = main_reg.byte_out;
    assign tlv_number  = main_reg.tlv_number;
    assign value_pos   = main_reg.value_pos;
    assign tlv_last    = main_reg.tlv_last;
    assign packet_last = main_reg.packet_last;
    assign error       = main_reg.error;

    // A filled skid entry always sits behind a valid result
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with empty result register");

    // Any error ends the packet
    a_err_ends_packet: assert property (@(posedge clk) disable iff (!rst_n)
        (main_valid_reg && main_reg.error != ERR_NONE) |-> main_reg.packet_last)
        else $error("error reported without packet end");

    // TLV end and value position only on value bytes
    a_value_only: assert property (@(posedge clk) disable iff (!rst_n)
        (main_valid_reg && (main_reg.tlv_last || main_reg.value_pos != 8'd0))
        |-> main_reg.kind == KIND_VALUE)
        else $error("value marks on a non-value byte");

    // A start request always leads to the length phase
    a_start_to_len: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && start_req) |=> phase_reg == PH_LEN)
        else $error("start request did not enter length phase");

    // After a packet-ending error the parser goes idle
    a_err_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && res.error != ERR_NONE) |=> phase_reg == PH_IDLE)
        else $error("parser not idle after error");

endmodule

`default_nettype wire
